@@ src/eswm_pkg.sv @@
// ---------------------------------------------------------------------------
// eswm_pkg: shared types and constants for the scaled world matrix block
// Holds the CORDIC arctangent table, the gain and the cell payload type.
// ---------------------------------------------------------------------------
package eswm_pkg;

   localparam int ANGLE_WIDTH     = 16;
   localparam int TRIG_ITERATIONS = 16;
   localparam int CORDIC_MAX      = 24;
   localparam int STEPS = (TRIG_ITERATIONS < CORDIC_MAX) ? TRIG_ITERATIONS : CORDIC_MAX;
   localparam int CW = 34;   // x, y in Q2.30 with growth headroom
   localparam int ZW = 33;   // reduced phase, signed
   localparam int TRIG_ROUND = 1 << 13;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   // One pitch/yaw/roll triple moving through a cell.
   typedef struct packed {
      rot_type [2:0] r;
      logic          flip_p;
      logic          flip_y;
      logic          flip_r;
   } trig_type;

   typedef struct packed {
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } side_type;

   typedef struct packed {
      logic signed [23:0] row1_col1;
      logic signed [23:0] row1_col2;
      logic signed [23:0] row1_col3;
      logic signed [23:0] row2_col1;
      logic signed [23:0] row2_col2;
      logic signed [23:0] row2_col3;
      logic signed [23:0] row3_col1;
      logic signed [23:0] row3_col2;
      logic signed [23:0] row3_col3;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        pitch_angle;
      logic [15:0]        yaw_angle;
      logic [15:0]        roll_angle;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   // Phase setup: quarter fold into [-1/4, 1/4) turn.
   function automatic rot_type fold_angle(input logic [15:0] angle, output logic flip);
      logic [31:0] phase;
      rot_type     r;
      phase = {angle[ANGLE_WIDTH-1:0], {(32-ANGLE_WIDTH){1'b0}}};
      flip  = phase[31] ^ phase[30];
      if (flip) begin
         phase = phase + 32'h80000000;
      end
      r.x = CORDIC_GAIN;
      r.y = '0;
      r.z = {phase[31], phase};
      return r;
   endfunction

   // Q1.16 rounding of a Q2.30 value, negated for folded angles.
   function automatic logic signed [17:0] round_trig(input logic signed [CW-1:0] v,
                                                     input logic flip);
      logic signed [CW-1:0] t;
      logic signed [CW-1:0] s;
      t = flip ? -v : v;
      s = (t + CW'(TRIG_ROUND)) >>> 14;
      return s[17:0];
   endfunction

endpackage

@@ src/eswm_if.sv @@
// ---------------------------------------------------------------------------
// eswm_if: valid/ready channel carrying one word of a given payload type
// Source drives valid and payload, sink drives ready.
// ---------------------------------------------------------------------------
interface eswm_req_if (input logic clock);
   import eswm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface eswm_rsp_if (input logic clock);
   import eswm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/eswm_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// eswm_cordic_cell: one CORDIC micro-rotation for three angles
// Rotates the pitch, yaw and roll vectors by one table step and passes them on.
// ---------------------------------------------------------------------------
module eswm_cordic_cell (
   input  logic                clock,
   input  logic                enable,
   input  logic [4:0]          step,
   input  eswm_pkg::trig_type  trig_in,
   input  eswm_pkg::side_type  side_in,
   output eswm_pkg::trig_type  trig_out,
   output eswm_pkg::side_type  side_out
);
   import eswm_pkg::*;

   trig_type trig_ff, trig_in_next;
   side_type side_ff;
   logic signed [ZW-1:0] angle_step;

   assign angle_step = {1'b0, ATAN_TURNS[step]};

   always_comb begin
      trig_in_next = trig_in;
      for (int a = 0; a < 3; a++) begin
         if (!trig_in.r[a].z[ZW-1]) begin
            trig_in_next.r[a].x = trig_in.r[a].x - (trig_in.r[a].y >>> step);
            trig_in_next.r[a].y = trig_in.r[a].y + (trig_in.r[a].x >>> step);
            trig_in_next.r[a].z = trig_in.r[a].z - angle_step;
         end else begin
            trig_in_next.r[a].x = trig_in.r[a].x + (trig_in.r[a].y >>> step);
            trig_in_next.r[a].y = trig_in.r[a].y - (trig_in.r[a].x >>> step);
            trig_in_next.r[a].z = trig_in.r[a].z + angle_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff <= trig_in_next;
         side_ff <= side_in;
      end
   end

   assign trig_out = trig_ff;
   assign side_out = side_ff;
endmodule

@@ src/eswm_matrix.sv @@
// ---------------------------------------------------------------------------
// eswm_matrix: entry products, rounding and row scaling
// Three registered stages turn sines and cosines into entries; scaling follows them.
// ---------------------------------------------------------------------------
module eswm_matrix (
   input  logic                clock,
   input  logic [2:0]          enable,
   input  eswm_pkg::trig_type  trig_in,
   input  eswm_pkg::side_type  side_in,
   output eswm_pkg::rsp_type   rsp_out
);
   import eswm_pkg::*;

   // Stage A: rounded sine and cosine, Q1.16.
   logic signed [17:0] sp_ff, cp_ff, sy_ff, cy_ff, sr_ff, cr_ff;
   side_type           sa_ff;
   // Stage B: pair products, Q.32.
   logic signed [35:0] sp_sy_ff, sp_cy_ff, cr_cy_ff, cr_sy_ff, sr_cy_ff, sr_sy_ff;
   logic signed [35:0] cp_sy_ff, cp_cy_ff, sr_cp_ff, cr_cp_ff;
   logic signed [17:0] sr_b_ff, cr_b_ff, sp_b_ff;
   side_type           sb_ff;
   // Stage C: rounded Q.16 rotation entries.
   logic signed [19:0] e_ff [9];
   side_type           sc_ff;

   logic signed [53:0] t1, t3, t4, t6;
   logic signed [19:0] e_in [9];

   function automatic logic signed [19:0] rnd48(input logic signed [53:0] v);
      logic signed [53:0] s;
      s = (v + 54'sd2147483648) >>> 32;
      return s[19:0];
   endfunction

   function automatic logic signed [23:0] scl(input logic signed [19:0] e,
                                              input logic signed [15:0] k);
      logic signed [35:0] p;
      logic signed [35:0] s;
      p = e * k;
      s = (p + 36'sd2048) >>> 12;
      if (s > 36'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (s < -36'sd8388608) begin
         return 24'sh800000;
      end
      return s[23:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         sp_ff <= round_trig(trig_in.r[0].y, trig_in.flip_p);
         cp_ff <= round_trig(trig_in.r[0].x, trig_in.flip_p);
         sy_ff <= round_trig(trig_in.r[1].y, trig_in.flip_y);
         cy_ff <= round_trig(trig_in.r[1].x, trig_in.flip_y);
         sr_ff <= round_trig(trig_in.r[2].y, trig_in.flip_r);
         cr_ff <= round_trig(trig_in.r[2].x, trig_in.flip_r);
         sa_ff <= side_in;
      end
      if (enable[1]) begin
         sp_sy_ff <= sp_ff * sy_ff;
         sp_cy_ff <= sp_ff * cy_ff;
         cr_cy_ff <= cr_ff * cy_ff;
         cr_sy_ff <= cr_ff * sy_ff;
         sr_cy_ff <= sr_ff * cy_ff;
         sr_sy_ff <= sr_ff * sy_ff;
         cp_sy_ff <= cp_ff * sy_ff;
         cp_cy_ff <= cp_ff * cy_ff;
         sr_cp_ff <= sr_ff * cp_ff;
         cr_cp_ff <= cr_ff * cp_ff;
         sr_b_ff  <= sr_ff;
         cr_b_ff  <= cr_ff;
         sp_b_ff  <= sp_ff;
         sb_ff    <= sa_ff;
      end
      if (enable[2]) begin
         for (int i = 0; i < 9; i++) begin
            e_ff[i] <= e_in[i];
         end
         sc_ff <= sb_ff;
      end
   end

   always_comb begin
      t1 = sr_b_ff * sp_sy_ff + (54'(cr_cy_ff) <<< 16);
      t3 = sr_b_ff * sp_cy_ff - (54'(cr_sy_ff) <<< 16);
      t4 = cr_b_ff * sp_sy_ff - (54'(sr_cy_ff) <<< 16);
      t6 = cr_b_ff * sp_cy_ff + (54'(sr_sy_ff) <<< 16);
      e_in[0] = rnd48(t1);
      e_in[1] = rnd48(54'(sr_cp_ff) <<< 16);
      e_in[2] = rnd48(t3);
      e_in[3] = rnd48(t4);
      e_in[4] = rnd48(54'(cr_cp_ff) <<< 16);
      e_in[5] = rnd48(t6);
      e_in[6] = rnd48(54'(cp_sy_ff) <<< 16);
      e_in[7] = rnd48(-(54'(sp_b_ff) <<< 32));
      e_in[8] = rnd48(54'(cp_cy_ff) <<< 16);
   end

   always_comb begin
      rsp_out.row1_col1 = scl(e_ff[0], sc_ff.scale_x);
      rsp_out.row1_col2 = scl(e_ff[1], sc_ff.scale_x);
      rsp_out.row1_col3 = scl(e_ff[2], sc_ff.scale_x);
      rsp_out.row2_col1 = scl(e_ff[3], sc_ff.scale_y);
      rsp_out.row2_col2 = scl(e_ff[4], sc_ff.scale_y);
      rsp_out.row2_col3 = scl(e_ff[5], sc_ff.scale_y);
      rsp_out.row3_col1 = scl(e_ff[6], sc_ff.scale_z);
      rsp_out.row3_col2 = scl(e_ff[7], sc_ff.scale_z);
      rsp_out.row3_col3 = scl(e_ff[8], sc_ff.scale_z);
      rsp_out.trans_x   = sc_ff.pos_x;
      rsp_out.trans_y   = sc_ff.pos_y;
      rsp_out.trans_z   = sc_ff.pos_z;
   end
endmodule

@@ src/euler_scale_world_matrix_top.sv @@
// ---------------------------------------------------------------------------
// euler_scale_world_matrix_top: scaled yaw/pitch/roll world matrix pipeline
// Chain of CORDIC cells, then product stages and a registered output word.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  req     | in  | req_valid/req_ready  | three angles, three scales, position
//  rsp     | out | rsp_valid/rsp_ready  | nine matrix entries, translation
//
//  One word enters per cycle while req_ready is high; it is registered into the
//  setup stage when accepted, then passes through each CORDIC cell, the three
//  product stages and the output register before rsp_valid rises for it.
//  A stage moves when the next is empty or moving; when the output word is held,
//  not taken, the pipe stalls and req_ready drops unless a slot ahead is empty.
//  Synchronous reset clears only the valid bits.
module euler_scale_world_matrix_top (
   input logic       clock,
   input logic       reset,
   eswm_req_if.sink   req,
   eswm_rsp_if.source rsp
);
   import eswm_pkg::*;

   localparam int NS = STEPS + 5;  // setup, cells, three product stages, output

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;
   trig_type      trig_c [STEPS+1];
   side_type      side_c [STEPS+1];
   trig_type      setup_ff;
   side_type      sside_ff;
   rsp_type       mat_w;
   rsp_type       out_ff;
   logic          f_p, f_y, f_r;
   rot_type       rp, ry, rr;

   // Stage i may move when the stage after it is empty or moving.
   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp.ready;
      for (int i = NS-2; i >= 0; i--) begin
         adv[i] = !vld_ff[i+1] || adv[i+1];
      end
   end

   assign req.ready = adv[0] || !vld_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (req.ready) begin
            vld_ff[0] <= req.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i] || !vld_ff[i]) begin
               vld_ff[i] <= vld_ff[i-1] && adv[i-1];
            end
         end
      end
   end

   always_comb begin
      rp = fold_angle(req.data.pitch_angle, f_p);
      ry = fold_angle(req.data.yaw_angle, f_y);
      rr = fold_angle(req.data.roll_angle, f_r);
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         setup_ff.r[0]  <= rp;
         setup_ff.r[1]  <= ry;
         setup_ff.r[2]  <= rr;
         setup_ff.flip_p <= f_p;
         setup_ff.flip_y <= f_y;
         setup_ff.flip_r <= f_r;
         sside_ff <= '{scale_x: req.data.scale_x, scale_y: req.data.scale_y,
                       scale_z: req.data.scale_z, pos_x: req.data.pos_x,
                       pos_y: req.data.pos_y, pos_z: req.data.pos_z};
      end
   end

   assign trig_c[0] = setup_ff;
   assign side_c[0] = sside_ff;

   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      eswm_cordic_cell u_cell (
         .clock    (clock),
         .enable   (adv[g+1] || !vld_ff[g+1]),
         .step     (5'(g)),
         .trig_in  (trig_c[g]),
         .side_in  (side_c[g]),
         .trig_out (trig_c[g+1]),
         .side_out (side_c[g+1])
      );
   end

   eswm_matrix u_matrix (
      .clock   (clock),
      .enable  ({adv[STEPS+3] || !vld_ff[STEPS+3], adv[STEPS+2] || !vld_ff[STEPS+2],
                 adv[STEPS+1] || !vld_ff[STEPS+1]}),
      .trig_in (trig_c[STEPS]),
      .side_in (side_c[STEPS]),
      .rsp_out (mat_w)
   );

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         out_ff <= mat_w;
      end
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.data  = out_ff;

   // A held output word must not change while it waits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("output word changed while stalled");
   // With the output free, the pipe always takes input.
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("input stalled with free output");
   // Number of words in flight never exceeds the stage count.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_ff) <= NS)
      else $error("occupancy out of range");
endmodule

@@ tb/sv/eswm_tb_if.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// eswm_tb_pkg: testbench constants for the matrix block
// Holds the pipeline depth used to drain the block at the end of a run.
// ---------------------------------------------------------------------------
package eswm_tb_pkg;
   import eswm_pkg::*;
   localparam int PIPE_LATENCY = STEPS + 5;
endpackage

@@ tb/sv/eswm_matrix_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// eswm_matrix_checker: predicts and checks scaled world matrix words
// Watches both channels; each accepted request word is turned into the
// expected matrix by a bit-exact CORDIC model and queued; each accepted
// response word is compared field by field with the oldest expectation.
// ---------------------------------------------------------------------------
module eswm_matrix_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  eswm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  eswm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import eswm_pkg::*;

   rsp_type expected_matrices[$];

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   // Sine and cosine of a binary angle in Q1.16.
   function automatic void angle_sin_cos(input logic [15:0] angle, output longint s_q16,
                                         output longint c_q16);
      logic [31:0] phase;
      logic        flip;
      longint      x, y, z, dx, dy;
      phase = {angle[ANGLE_WIDTH-1:0], {(32-ANGLE_WIDTH){1'b0}}};
      flip  = phase[31] ^ phase[30];
      if (flip) begin
         phase = phase + 32'h80000000;
      end
      z = longint'($signed(phase));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c_q16 = floor_shift(x + 8192, 14);
      s_q16 = floor_shift(y + 8192, 14);
   endfunction

   function automatic logic signed [23:0] scaled_entry(input longint q48,
                                                       input longint scale);
      longint e, r;
      e = floor_shift(q48 + (longint'(1) << 31), 32);
      r = floor_shift(e * scale + 2048, 12);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
   endfunction

   function automatic rsp_type world_matrix(input req_type w);
      longint sp, cp, sy, cy, sr, cr, kx, ky, kz, one;
      rsp_type m;
      angle_sin_cos(w.pitch_angle, sp, cp);
      angle_sin_cos(w.yaw_angle, sy, cy);
      angle_sin_cos(w.roll_angle, sr, cr);
      kx  = w.scale_x;
      ky  = w.scale_y;
      kz  = w.scale_z;
      one = 65536;
      m.row1_col1 = scaled_entry(sr * sp * sy + cr * cy * one, kx);
      m.row1_col2 = scaled_entry(sr * cp * one, kx);
      m.row1_col3 = scaled_entry(sr * sp * cy - cr * sy * one, kx);
      m.row2_col1 = scaled_entry(cr * sp * sy - sr * cy * one, ky);
      m.row2_col2 = scaled_entry(cr * cp * one, ky);
      m.row2_col3 = scaled_entry(cr * sp * cy + sr * sy * one, ky);
      m.row3_col1 = scaled_entry(cp * sy * one, kz);
      m.row3_col2 = scaled_entry(-sp * one * one, kz);
      m.row3_col3 = scaled_entry(cp * cy * one, kz);
      m.trans_x   = w.pos_x;
      m.trans_y   = w.pos_y;
      m.trans_z   = w.pos_z;
      return m;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matrices.size() == 0) begin
            $error("response word with no request outstanding");
            fail_count++;
         end else begin
            e = expected_matrices.pop_front();
            check_field("row1_col1", e.row1_col1, rsp_data.row1_col1);
            check_field("row1_col2", e.row1_col2, rsp_data.row1_col2);
            check_field("row1_col3", e.row1_col3, rsp_data.row1_col3);
            check_field("row2_col1", e.row2_col1, rsp_data.row2_col1);
            check_field("row2_col2", e.row2_col2, rsp_data.row2_col2);
            check_field("row2_col3", e.row2_col3, rsp_data.row2_col3);
            check_field("row3_col1", e.row3_col1, rsp_data.row3_col1);
            check_field("row3_col2", e.row3_col2, rsp_data.row3_col2);
            check_field("row3_col3", e.row3_col3, rsp_data.row3_col3);
            check_field("trans_x", e.trans_x, rsp_data.trans_x);
            check_field("trans_y", e.trans_y, rsp_data.trans_y);
            check_field("trans_z", e.trans_z, rsp_data.trans_z);
         end
      end
      if (!reset && req_valid && req_ready) begin
         expected_matrices.push_back(world_matrix(req_data));
      end
      pending_count = expected_matrices.size();
   end

endmodule

@@ tb/sv/tb_euler_scale_world_matrix_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_euler_scale_world_matrix_top: stimulus and verdict for the matrix block
// Sends directed angle/scale/position words, then random ones, with random
// idling on both sides; the checker compares every response word.
// ---------------------------------------------------------------------------
module tb_euler_scale_world_matrix_top;
   import eswm_pkg::*;

   localparam int RANDOM_WORDS = 1300;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock;
   logic    reset;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   bit      quiet_stretch;

   eswm_req_if req (clock);
   eswm_rsp_if rsp (clock);

   euler_scale_world_matrix_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   eswm_matrix_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_data      (req.data),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_data      (rsp.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Receiver stalls at random, except during the quiet stretch.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= quiet_stretch || ($urandom_range(99) >= 7);
      end
   end

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(5))
         0: return 16'(32'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
         1: return {2'($urandom_range(3)), 14'h0};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(input req_type w);
      req.valid <= 1'b1;
      req.data  <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      if (!quiet_stretch && $urandom_range(99) < 7) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   initial begin
      req_type w;
      logic [15:0] corner_angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                         16'hFFFF, 16'h3FFF, 16'h7FFF, 16'h2000};
      quiet_stretch = 1'b0;
      reset     = 1'b1;
      req.valid = 1'b0;
      req.data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Quarter boundaries, extreme scales and positions.
      for (int i = 0; i < 8; i++) begin
         w.pitch_angle = corner_angles[i];
         w.yaw_angle   = corner_angles[(i + 3) % 8];
         w.roll_angle  = corner_angles[(i + 5) % 8];
         w.scale_x     = (i % 2) ? 16'sh7FFF : 16'sh8000;
         w.scale_y     = (i % 2) ? 16'sh8000 : 16'sh7FFF;
         w.scale_z     = (i < 4) ? 16'sh1000 : 16'sh0000;
         w.pos_x       = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
         w.pos_y       = (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
         w.pos_z       = (i % 3) ? 32'sh00000000 : 32'shFFFFFFFF;
         send_word(w);
      end
      w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh8000, 16'sh8000,
            32'sh80000000, 32'sh80000000, 32'sh80000000};
      send_word(w);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet_stretch = (n >= 400 && n < 600);
         w.pitch_angle = pick_angle();
         w.yaw_angle   = pick_angle();
         w.roll_angle  = pick_angle();
         w.scale_x     = pick_scale();
         w.scale_y     = pick_scale();
         w.scale_z     = pick_scale();
         w.pos_x       = $urandom;
         w.pos_y       = $urandom;
         w.pos_z       = $urandom;
         send_word(w);
      end
      req.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (eswm_tb_pkg::PIPE_LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
